// ----- hw/rtl/shp_pkg.sv -----
// ----------------------------------------------------------------------------
// shp_pkg
// Shared constants, command codes and item types of the sparse Hadamard
// projection core.
// ----------------------------------------------------------------------------
package shp_pkg;

  // sizing of the tables and the output store
  localparam int MAX_POSITIONS = 64;
  localparam int MAX_ROWS      = 64;
  localparam int KEY_BITS      = 10;

  // field widths of the channels
  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int HIDX_W = 10;
  localparam int KEY_W  = 10;
  localparam int SIGN_W = 2;
  localparam int ROW_W  = 6;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 40;
  localparam int AP_W   = 7;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [AP_W-1:0] AP_RESET = 7'd64;
  localparam logic REG_ACTIVE_POSITIONS = 1'b0;

  // derived widths
  localparam int POS_AW     = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int POS_CW     = $clog2(MAX_POSITIONS + 1);
  localparam int ROW_AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ST_DEPTH   = MAX_ROWS * MAX_POSITIONS;
  localparam int ST_AW      = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
  localparam int SIGN_DEPTH = 1 << KEY_BITS;
  localparam int SIGN_AW    = KEY_BITS;
  localparam int BASE_W     = VAL_W + 2;

  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'(1) << KEY_BITS) - 64'(1));
  localparam logic [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

  // decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_INDEX = 3'd0,
    CMD_LOAD_SIGN  = 3'd1,
    CMD_ACCUMULATE = 3'd2,
    CMD_READ       = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    OP_LOAD_INDEX,
    OP_LOAD_SIGN,
    OP_ACCUMULATE,
    OP_READ,
    OP_READ_ZERO,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [POS_W-1:0]         pos;
    logic [HIDX_W-1:0]        hidx;
    logic [KEY_W-1:0]         key;
    logic signed [SIGN_W-1:0] sign;
    logic [ROW_W-1:0]         row;
    logic signed [VAL_W-1:0]  value;
  } item_t;

endpackage

// ----- hw/rtl/sparse_hadamard_projection_core.sv -----
// ----------------------------------------------------------------------------
// sparse_hadamard_projection_core
// Sparse randomized Hadamard projection with index table, sign table and a
// saturating Q24.16 output store.
// ----------------------------------------------------------------------------
// Items pass through a two-entry queue to an execution engine that works on
// one item at a time. Index loads, sign loads, clears and out-of-range reads
// finish in the idle state, while an in-range read passes through a read
// state. An accumulate sweeps n positions, where n is active_positions (capped
// at 64); the first accumulate into a row after reset or a clear sweeps all 64
// positions, writing zeros past n. The output store has a single read-modify-write path, one position
// per cycle, which sets the accumulate time. Clears act on per-row valid bits
// and need no sweep; the block is ready right after reset.
// ----------------------------------------------------------------------------
module sparse_hadamard_projection_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [shp_pkg::CMD_W-1:0]         in_command,
  input  logic [shp_pkg::POS_W-1:0]         in_position,
  input  logic [shp_pkg::HIDX_W-1:0]        in_hadamard_index,
  input  logic [shp_pkg::KEY_W-1:0]         in_key,
  input  logic signed [shp_pkg::SIGN_W-1:0] in_sign_value,
  input  logic [shp_pkg::ROW_W-1:0]         in_row,
  input  logic signed [shp_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [shp_pkg::ACC_W-1:0]  out_read_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [shp_pkg::CFG_AW-1:0]        paddr,
  input  logic [shp_pkg::CFG_DW-1:0]        pwdata,
  output logic [shp_pkg::CFG_DW-1:0]        prdata,
  output logic                              pready
);
  import shp_pkg::*;

  logic [AP_W-1:0] active_positions_r;
  logic            cfg_wr;
  logic            q_full;
  logic            push;
  item_t           push_item;
  logic            head_valid;
  item_t           head_item;
  logic            head_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_positions_r <= AP_RESET;
    end else if (cfg_wr && paddr[2] == REG_ACTIVE_POSITIONS) begin
      active_positions_r <= pwdata[AP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ACTIVE_POSITIONS) ? CFG_DW'(active_positions_r) : '0;

  shp_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_hadamard_index (in_hadamard_index),
    .in_key            (in_key),
    .in_sign_value     (in_sign_value),
    .in_row            (in_row),
    .in_value          (in_value),
    .q_full            (q_full),
    .push              (push),
    .push_item         (push_item)
  );

  shp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (head_pop)
  );

  shp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_item        (head_item),
    .head_pop         (head_pop),
    .active_positions (active_positions_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data)
  );

endmodule

// ----- hw/rtl/shp_ram.sv -----
// ----------------------------------------------------------------------------
// shp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/shp_front.sv -----
// ----------------------------------------------------------------------------
// shp_front
// Accepts input items, classifies each command and pushes the work that the
// back end has to do into the queue. Commands without effect are dropped here.
// ----------------------------------------------------------------------------
module shp_front (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [shp_pkg::CMD_W-1:0]         in_command,
  input  logic [shp_pkg::POS_W-1:0]         in_position,
  input  logic [shp_pkg::HIDX_W-1:0]        in_hadamard_index,
  input  logic [shp_pkg::KEY_W-1:0]         in_key,
  input  logic signed [shp_pkg::SIGN_W-1:0] in_sign_value,
  input  logic [shp_pkg::ROW_W-1:0]         in_row,
  input  logic signed [shp_pkg::VAL_W-1:0]  in_value,
  input  logic                              q_full,
  output logic                              push,
  output shp_pkg::item_t                    push_item
);
  import shp_pkg::*;

  logic keep;
  logic pos_ok;
  logic row_ok;

  assign pos_ok   = 32'(in_position) < MAX_POSITIONS;
  assign row_ok   = 32'(in_row) < MAX_ROWS;
  assign in_stall = q_full;

  always_comb begin
    keep         = 1'b1;
    push_item.op = OP_CLEAR;
    case (cmd_t'(in_command))
      CMD_LOAD_INDEX: begin
        push_item.op = OP_LOAD_INDEX;
        keep         = pos_ok;
      end
      CMD_LOAD_SIGN: begin
        push_item.op = OP_LOAD_SIGN;
      end
      CMD_ACCUMULATE: begin
        push_item.op = OP_ACCUMULATE;
        keep         = row_ok;
      end
      CMD_READ: begin
        // out-of-range reads still answer, with zero
        push_item.op = (pos_ok && row_ok) ? OP_READ : OP_READ_ZERO;
      end
      CMD_CLEAR: begin
        push_item.op = OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    push_item.pos   = in_position;
    push_item.hidx  = in_hadamard_index;
    push_item.key   = in_key & KEY_MASK;
    push_item.sign  = in_sign_value;
    push_item.row   = in_row;
    push_item.value = in_value;
  end

  assign push = in_valid && !q_full && keep;

endmodule

// ----- hw/rtl/shp_queue.sv -----
// ----------------------------------------------------------------------------
// shp_queue
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module shp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  shp_pkg::item_t push_item,
  output logic           full,
  output logic           head_valid,
  output shp_pkg::item_t head_item,
  input  logic           pop
);
  import shp_pkg::*;

  item_t               entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;

  assign full       = count_r == QUEUE_CW'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= push_item;
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/shp_back.sv -----
// ----------------------------------------------------------------------------
// shp_back
// Executes queued items: table loads, row clears, reads, and the per-position
// read-modify-write sweep of an accumulate over the output store.
// ----------------------------------------------------------------------------
module shp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  shp_pkg::item_t                    head_item,
  output logic                              head_pop,
  input  logic [shp_pkg::AP_W-1:0]          active_positions,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [shp_pkg::ACC_W-1:0]  out_read_data
);
  import shp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIGN,
    S_RUN,
    S_DRAIN,
    S_READ
  } state_t;

  state_t                    state_r;
  logic [KEY_W-1:0]          key_r;
  logic [ROW_AW-1:0]         row_r;
  logic signed [VAL_W-1:0]   val_r;
  logic signed [BASE_W-1:0]  base_r;
  logic [POS_CW-1:0]         p_r;
  logic [POS_CW-1:0]         lim_r;
  logic [POS_CW-1:0]         n_r;
  logic                      fresh_r;
  logic [MAX_ROWS-1:0]       row_valid_r;
  logic                      s1_v_r;
  logic [POS_AW-1:0]         s1_p_r;
  logic                      s1_zero_r;
  logic                      rd_live_r;
  logic                      out_valid_r;
  logic signed [ACC_W-1:0]   out_data_r;

  logic [ROW_AW-1:0]         head_row;
  logic [POS_AW-1:0]         head_pos;
  logic [POS_CW-1:0]         n_cfg;
  logic [HIDX_W-1:0]         idx_rdata;
  logic [SIGN_W-1:0]         sign_rdata;
  logic [ACC_W-1:0]          st_rdata;
  logic [ST_AW-1:0]          st_raddr;
  logic [ST_AW-1:0]          st_waddr;
  logic signed [ACC_W-1:0]   st_wdata;
  logic signed [BASE_W-1:0]  base_nxt;
  logic signed [BASE_W-1:0]  delta;
  logic signed [ACC_W-1:0]   old_val;
  logic signed [ACC_W:0]     sum;
  logic signed [ACC_W-1:0]   sat_val;
  logic                      par;
  logic                      idx_we;
  logic                      sign_we;

  function automatic logic [ST_AW-1:0] st_addr(input logic [ROW_AW-1:0] r,
                                               input logic [POS_AW-1:0] p);
    st_addr = ST_AW'(r) * ST_AW'(MAX_POSITIONS) + ST_AW'(p);
  endfunction

  assign head_row = ROW_AW'(head_item.row);
  assign head_pos = POS_AW'(head_item.pos);
  assign n_cfg    = (32'(active_positions) > MAX_POSITIONS) ?
                    POS_CW'(MAX_POSITIONS) : POS_CW'(active_positions);

  // reads need the output register free
  always_comb begin
    head_pop = 1'b0;
    if (state_r == S_IDLE && head_valid) begin
      if (head_item.op == OP_READ || head_item.op == OP_READ_ZERO) begin
        head_pop = !out_valid_r;
      end else begin
        head_pop = 1'b1;
      end
    end
  end

  assign idx_we  = head_pop && head_item.op == OP_LOAD_INDEX;
  assign sign_we = head_pop && head_item.op == OP_LOAD_SIGN;

  assign st_raddr = (state_r == S_RUN) ? st_addr(row_r, p_r[POS_AW-1:0])
                                       : st_addr(head_row, head_pos);
  assign st_waddr = st_addr(row_r, s1_p_r);

  // second stage of the sweep: sign by parity, saturating add
  always_comb begin
    base_nxt = BASE_W'(val_r) * BASE_W'($signed(sign_rdata));
    par      = ^(idx_rdata & key_r);
    delta    = par ? -base_r : base_r;
    old_val  = fresh_r ? '0 : $signed(st_rdata);
    sum      = (ACC_W+1)'(old_val) + (ACC_W+1)'(delta);
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat_val = sum[ACC_W] ? $signed(ACC_MIN) : $signed(ACC_MAX);
    end else begin
      sat_val = sum[ACC_W-1:0];
    end
    st_wdata = s1_zero_r ? '0 : sat_val;
  end

  shp_ram #(.WIDTH(HIDX_W), .DEPTH(MAX_POSITIONS)) u_index_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (head_pos),
    .wdata (head_item.hidx),
    .raddr (p_r[POS_AW-1:0]),
    .rdata (idx_rdata)
  );

  shp_ram #(.WIDTH(SIGN_W), .DEPTH(SIGN_DEPTH)) u_sign_ram (
    .clk   (clk),
    .we    (sign_we),
    .waddr (SIGN_AW'(head_item.key)),
    .wdata (head_item.sign),
    .raddr (SIGN_AW'(head_item.key)),
    .rdata (sign_rdata)
  );

  shp_ram #(.WIDTH(ACC_W), .DEPTH(ST_DEPTH)) u_store_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_valid_r <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (head_pop) begin
            case (head_item.op)
              OP_ACCUMULATE: begin
                key_r   <= head_item.key;
                row_r   <= head_row;
                val_r   <= head_item.value;
                n_r     <= n_cfg;
                p_r     <= '0;
                // a row untouched since clear is swept whole, zeros past n
                fresh_r <= !row_valid_r[head_row];
                lim_r   <= row_valid_r[head_row] ? n_cfg : POS_CW'(MAX_POSITIONS);
                row_valid_r[head_row] <= 1'b1;
                state_r <= S_SIGN;
              end
              OP_READ: begin
                rd_live_r <= row_valid_r[head_row];
                state_r   <= S_READ;
              end
              OP_READ_ZERO: begin
                out_valid_r <= 1'b1;
                out_data_r  <= '0;
              end
              OP_CLEAR: begin
                row_valid_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SIGN: begin
          base_r  <= base_nxt;
          state_r <= (lim_r == '0) ? S_IDLE : S_RUN;
        end
        S_RUN: begin
          s1_v_r    <= 1'b1;
          s1_p_r    <= p_r[POS_AW-1:0];
          s1_zero_r <= p_r >= n_r;
          p_r       <= p_r + 1'b1;
          if (p_r + 1'b1 == lim_r) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_IDLE;
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_data_r  <= rd_live_r ? $signed(st_rdata) : '0;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule
